// File: rtl/adt_pkg.sv
// shared constants and request codes for the alarm deadline table
package adt_pkg;

    localparam int NUM_ALARMS = 32;
    localparam int TIME_BITS  = 48;

    localparam int REQ_W   = 2;
    localparam int ID_W    = 5;
    localparam int DELAY_W = 40;
    localparam int NOW_W   = 48;
    localparam int NEXT_W  = 48;
    localparam int COUNT_W = 6;

    localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int CNT_W = $clog2(NUM_ALARMS + 1);
    localparam int SUM_W = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;

    localparam logic [63:0] NEXT_MAX = (64'd1 << NEXT_W) - 64'd1;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

endpackage

// File: rtl/alarm_deadline_table.sv
// alarm deadline table: request sequencer, armed flags and output register
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  request  | in_valid / in_stall      | req_type, alarm_id, delay_us, now_us
//  result   | out_valid / out_stall    | expired_valid, expired_id, next_valid,
//           |                          | next_run_us, active_count, last
//
// one request at a time: an update step, then a memory sweep (one slot a cycle, then
// the registered read and a drain step), then the final beat; a run also walks the
// expired slots, one beat each, before the final beat; result stalls hold the beats
// reset clears all armed flags and the count; deadlines are not cleared
// in_stall is high from acceptance until the final beat is loaded, so the next
// request is accepted in the cycle after that at the earliest
module alarm_deadline_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [adt_pkg::REQ_W-1:0]   req_type,
    input  logic [adt_pkg::ID_W-1:0]    alarm_id,
    input  logic [adt_pkg::DELAY_W-1:0] delay_us,
    input  logic [adt_pkg::NOW_W-1:0]   now_us,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        expired_valid,
    output logic [adt_pkg::ID_W-1:0]    expired_id,
    output logic                        next_valid,
    output logic [adt_pkg::NEXT_W-1:0]  next_run_us,
    output logic [adt_pkg::COUNT_W-1:0] active_count,
    output logic                        last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_LAST   = 3'd4;

    // control state
    logic [2:0]                         state_reg, state_next;
    logic [adt_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                               rd_vld_reg, rd_vld_next;
    logic [adt_pkg::NUM_ALARMS-1:0]     armed_reg, armed_next;
    logic [adt_pkg::NUM_ALARMS-1:0]     hit_reg, hit_next;
    logic [adt_pkg::CNT_W-1:0]          count_reg, count_next;
    logic                               best_vld_reg, best_vld_next;
    logic                               out_valid_reg, out_valid_next;

    // payload
    logic [adt_pkg::REQ_W-1:0]          req_reg, req_next;
    logic [adt_pkg::ID_W-1:0]           id_reg, id_next;
    logic [adt_pkg::DELAY_W-1:0]        delay_reg, delay_next;
    logic [adt_pkg::TIME_BITS-1:0]      now_reg, now_next;
    logic [adt_pkg::IDX_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [adt_pkg::TIME_BITS-1:0]      best_reg, best_next;
    logic                               exp_vld_reg, exp_vld_next;
    logic [adt_pkg::ID_W-1:0]           exp_id_reg, exp_id_next;
    logic                               nxt_vld_reg, nxt_vld_next;
    logic [adt_pkg::NEXT_W-1:0]         nxt_run_reg, nxt_run_next;
    logic [adt_pkg::COUNT_W-1:0]        act_cnt_reg, act_cnt_next;
    logic                               last_reg, last_next;

    // memory port
    logic                               ram_wr_en;
    logic [adt_pkg::IDX_W-1:0]          ram_wr_addr;
    logic [adt_pkg::TIME_BITS-1:0]      ram_wr_data;
    logic                               ram_rd_en;
    logic [adt_pkg::IDX_W-1:0]          ram_rd_addr;
    logic [adt_pkg::TIME_BITS-1:0]      ram_rd_data;

    logic                               in_accept;
    logic                               out_free;
    logic                               id_in_range;
    logic [adt_pkg::IDX_W-1:0]          id_idx;
    logic [adt_pkg::SUM_W-1:0]          sum;
    logic [adt_pkg::TIME_BITS-1:0]      wait_val;
    logic [63:0]                        wait_ext;
    logic [adt_pkg::NEXT_W-1:0]         wait_sat;

    adt_deadline_ram #(
        .DEPTH (adt_pkg::NUM_ALARMS),
        .WIDTH (adt_pkg::TIME_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign id_in_range = (int'(id_reg) < adt_pkg::NUM_ALARMS);
    assign id_idx      = adt_pkg::IDX_W'(id_reg);

    // deadline saturates at the top of the time line
    assign sum = adt_pkg::SUM_W'(now_reg) + adt_pkg::SUM_W'(delay_reg);

    assign wait_val = (best_reg > now_reg) ? (best_reg - now_reg) : '0;
    assign wait_ext = 64'(wait_val);
    assign wait_sat = (wait_ext > adt_pkg::NEXT_MAX) ? adt_pkg::NEXT_W'(adt_pkg::NEXT_MAX)
                                                     : adt_pkg::NEXT_W'(wait_ext);

    assign ram_wr_addr = id_idx;
    assign ram_rd_addr = adt_pkg::IDX_W'(cnt_reg);
    assign ram_rd_en   = (state_reg == S_SCAN) && (int'(cnt_reg) < adt_pkg::NUM_ALARMS);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        armed_next     = armed_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        best_vld_next  = best_vld_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        id_next        = id_reg;
        delay_next     = delay_reg;
        now_next       = now_reg;
        rd_idx_next    = rd_idx_reg;
        best_next      = best_reg;
        exp_vld_next   = exp_vld_reg;
        exp_id_next    = exp_id_reg;
        nxt_vld_next   = nxt_vld_reg;
        nxt_run_next   = nxt_run_reg;
        act_cnt_next   = act_cnt_reg;
        last_next      = last_reg;
        ram_wr_en      = 1'b0;
        ram_wr_data    = now_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next      = req_type;
                    id_next       = alarm_id;
                    delay_next    = delay_us;
                    now_next      = adt_pkg::TIME_BITS'(now_us);
                    hit_next      = '0;
                    best_vld_next = 1'b0;
                    cnt_next      = '0;
                    state_next    = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                if (id_in_range)
                begin
                    if (req_reg == adt_pkg::REQ_ADD)
                    begin
                        ram_wr_en = 1'b1;
                        if (sum[adt_pkg::SUM_W-1:adt_pkg::TIME_BITS] != '0)
                        begin
                            ram_wr_data = '1;
                        end
                        else
                        begin
                            ram_wr_data = sum[adt_pkg::TIME_BITS-1:0];
                        end
                        if (!armed_reg[id_idx])
                        begin
                            armed_next[id_idx] = 1'b1;
                            count_next         = count_reg + 1'b1;
                        end
                    end
                    else if (req_reg == adt_pkg::REQ_DELETE)
                    begin
                        if (armed_reg[id_idx])
                        begin
                            armed_next[id_idx] = 1'b0;
                            count_next         = count_reg - 1'b1;
                        end
                    end
                end
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (ram_rd_en)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = adt_pkg::IDX_W'(cnt_reg);
                    cnt_next    = cnt_reg + 1'b1;
                end
                // read data is registered and arrives in the cycle after its address
                if (rd_vld_reg && armed_reg[rd_idx_reg])
                begin
                    if ((req_reg == adt_pkg::REQ_RUN) && (ram_rd_data <= now_reg))
                    begin
                        hit_next[rd_idx_reg]   = 1'b1;
                        armed_next[rd_idx_reg] = 1'b0;
                        count_next             = count_next - 1'b1;
                    end
                    else if (!best_vld_reg || (ram_rd_data < best_reg))
                    begin
                        best_next     = ram_rd_data;
                        best_vld_next = 1'b1;
                    end
                end
                if (!ram_rd_en && !rd_vld_reg)
                begin
                    cnt_next   = '0;
                    state_next = (req_reg == adt_pkg::REQ_RUN) ? S_EMIT : S_LAST;
                end
            end

            S_EMIT:
            begin
                if (int'(cnt_reg) >= adt_pkg::NUM_ALARMS)
                begin
                    state_next = S_LAST;
                end
                else if (!hit_reg[adt_pkg::IDX_W'(cnt_reg)])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    exp_vld_next   = 1'b1;
                    exp_id_next    = adt_pkg::ID_W'(cnt_reg);
                    nxt_vld_next   = 1'b0;
                    nxt_run_next   = '0;
                    act_cnt_next   = adt_pkg::COUNT_W'(count_reg);
                    last_next      = 1'b0;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end

            S_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    exp_vld_next   = 1'b0;
                    exp_id_next    = '0;
                    nxt_vld_next   = best_vld_reg;
                    nxt_run_next   = best_vld_reg ? wait_sat : '0;
                    act_cnt_next   = adt_pkg::COUNT_W'(count_reg);
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            armed_reg     <= '0;
            hit_reg       <= '0;
            count_reg     <= '0;
            best_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            armed_reg     <= armed_next;
            hit_reg       <= hit_next;
            count_reg     <= count_next;
            best_vld_reg  <= best_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        id_reg      <= id_next;
        delay_reg   <= delay_next;
        now_reg     <= now_next;
        rd_idx_reg  <= rd_idx_next;
        best_reg    <= best_next;
        exp_vld_reg <= exp_vld_next;
        exp_id_reg  <= exp_id_next;
        nxt_vld_reg <= nxt_vld_next;
        nxt_run_reg <= nxt_run_next;
        act_cnt_reg <= act_cnt_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign expired_valid = exp_vld_reg;
    assign expired_id    = exp_id_reg;
    assign next_valid    = nxt_vld_reg;
    assign next_run_us   = nxt_run_reg;
    assign active_count  = act_cnt_reg;
    assign last          = last_reg;

endmodule

// File: rtl/adt_deadline_ram.sv
// single-port-write, single-port-read deadline memory with registered read
module adt_deadline_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 48
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sim/testbench.sv
// self-checking testbench for the alarm deadline table
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic                        expired_v;
        logic [adt_pkg::ID_W-1:0]    expired_slot;
        logic                        next_v;
        logic [adt_pkg::NEXT_W-1:0]  wait_us;
        logic [adt_pkg::COUNT_W-1:0] armed_now;
        logic                        final_beat;
    } alarm_result_t;

    // mirror of the alarm table plus the results still owed by the block
    class deadline_checker;
        logic [adt_pkg::TIME_BITS-1:0] deadline [adt_pkg::NUM_ALARMS];
        bit                            armed [adt_pkg::NUM_ALARMS];
        int unsigned                   armed_total;
        alarm_result_t                 awaited [$];
        int unsigned                   errors;
        int unsigned                   requests_seen;
        int unsigned                   results_seen;
        int unsigned                   expiries_seen;

        function new();
            for (int i = 0; i < adt_pkg::NUM_ALARMS; i++)
                armed[i] = 1'b0;
            armed_total   = 0;
            errors        = 0;
            requests_seen = 0;
            results_seen  = 0;
            expiries_seen = 0;
        endfunction

        function void accept_request(logic [adt_pkg::REQ_W-1:0] req,
                                     logic [adt_pkg::ID_W-1:0] id,
                                     logic [adt_pkg::DELAY_W-1:0] delay,
                                     logic [adt_pkg::NOW_W-1:0] now);
            logic [adt_pkg::TIME_BITS:0]   sum;
            logic [adt_pkg::TIME_BITS-1:0] best;
            bit                            found;
            bit                            hit [adt_pkg::NUM_ALARMS];
            alarm_result_t                 r;
            requests_seen++;
            for (int i = 0; i < adt_pkg::NUM_ALARMS; i++)
                hit[i] = 1'b0;
            case (req)
                adt_pkg::REQ_ADD:
                begin
                    if (int'(id) < adt_pkg::NUM_ALARMS)
                    begin
                        sum = {1'b0, now}
                            + {{(adt_pkg::TIME_BITS+1-adt_pkg::DELAY_W){1'b0}}, delay};
                        // saturate at the top of the time line
                        if (sum[adt_pkg::TIME_BITS])
                            sum = {1'b0, {adt_pkg::TIME_BITS{1'b1}}};
                        deadline[id] = sum[adt_pkg::TIME_BITS-1:0];
                        if (!armed[id])
                        begin
                            armed[id] = 1'b1;
                            armed_total++;
                        end
                    end
                end
                adt_pkg::REQ_DELETE:
                begin
                    if (int'(id) < adt_pkg::NUM_ALARMS && armed[id])
                    begin
                        armed[id] = 1'b0;
                        armed_total--;
                    end
                end
                adt_pkg::REQ_RUN:
                begin
                    for (int i = 0; i < adt_pkg::NUM_ALARMS; i++)
                    begin
                        if (armed[i] && deadline[i] <= now)
                        begin
                            hit[i]   = 1'b1;
                            armed[i] = 1'b0;
                            armed_total--;
                        end
                    end
                end
                default: ;
            endcase
            // expiry beats carry the count after the whole request
            for (int i = 0; i < adt_pkg::NUM_ALARMS; i++)
            begin
                if (hit[i])
                begin
                    r.expired_v    = 1'b1;
                    r.expired_slot = adt_pkg::ID_W'(i);
                    r.next_v       = 1'b0;
                    r.wait_us      = '0;
                    r.armed_now    = adt_pkg::COUNT_W'(armed_total);
                    r.final_beat   = 1'b0;
                    awaited.push_back(r);
                end
            end
            found = 1'b0;
            best  = '0;
            for (int i = 0; i < adt_pkg::NUM_ALARMS; i++)
            begin
                if (armed[i] && (!found || deadline[i] < best))
                begin
                    best  = deadline[i];
                    found = 1'b1;
                end
            end
            r.expired_v    = 1'b0;
            r.expired_slot = '0;
            r.next_v       = found;
            r.wait_us      = (found && best > now) ? adt_pkg::NEXT_W'(best - now) : '0;
            r.armed_now    = adt_pkg::COUNT_W'(armed_total);
            r.final_beat   = 1'b1;
            awaited.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, field, want, seen);
            end
        endfunction

        function void check_result(alarm_result_t got);
            alarm_result_t want;
            results_seen++;
            if (got.expired_v === 1'b1)
                expiries_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result with none expected, expired_id %0h last %0b",
                             $time, got.expired_slot, got.final_beat);
                return;
            end
            want = awaited.pop_front();
            compare("expired_valid", want.expired_v, got.expired_v);
            compare("expired_id", want.expired_slot, got.expired_slot);
            compare("next_valid", want.next_v, got.next_v);
            compare("next_run_us", want.wait_us, got.wait_us);
            compare("active_count", want.armed_now, got.armed_now);
            compare("last", want.final_beat, got.final_beat);
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [adt_pkg::REQ_W-1:0]   req_type = adt_pkg::REQ_QUERY;
    logic [adt_pkg::ID_W-1:0]    alarm_id = '0;
    logic [adt_pkg::DELAY_W-1:0] delay_us = '0;
    logic [adt_pkg::NOW_W-1:0]   now_us = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        expired_valid;
    logic [adt_pkg::ID_W-1:0]    expired_id;
    logic                        next_valid;
    logic [adt_pkg::NEXT_W-1:0]  next_run_us;
    logic [adt_pkg::COUNT_W-1:0] active_count;
    logic                        last;

    deadline_checker           sb;
    alarm_result_t             seen_beat;
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    bit                        hold_req = 1'b0;
    int                        hold_left = 0;
    logic [adt_pkg::NOW_W-1:0] clock_us;

    alarm_deadline_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .alarm_id      (alarm_id),
        .delay_us      (delay_us),
        .now_us        (now_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .expired_valid (expired_valid),
        .expired_id    (expired_id),
        .next_valid    (next_valid),
        .next_run_us   (next_run_us),
        .active_count  (active_count),
        .last          (last)
    );

    always #10 clk = ~clk;

    // result side: check accepted beats, then choose the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_beat.expired_v    = expired_valid;
            seen_beat.expired_slot = expired_id;
            seen_beat.next_v       = next_valid;
            seen_beat.wait_us      = next_run_us;
            seen_beat.armed_now    = active_count;
            seen_beat.final_beat   = last;
            sb.check_result(seen_beat);
        end
        if (hold_req)
        begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic offer_request(input logic [adt_pkg::REQ_W-1:0] req,
                                 input logic [adt_pkg::ID_W-1:0] id,
                                 input logic [adt_pkg::DELAY_W-1:0] delay,
                                 input logic [adt_pkg::NOW_W-1:0] now);
        int gap;
        in_valid <= 1'b1;
        req_type <= req;
        alarm_id <= id;
        delay_us <= delay;
        now_us   <= now;
        do
            @(posedge clk);
        while (in_stall);
        sb.accept_request(req, id, delay, now);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_request();
        int                          pick;
        logic [adt_pkg::REQ_W-1:0]   req;
        logic [adt_pkg::DELAY_W-1:0] delay;
        logic [adt_pkg::NOW_W-1:0]   now;
        logic [63:0]                 wide;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            req = adt_pkg::REQ_ADD;
        else if (pick < 55)
            req = adt_pkg::REQ_DELETE;
        else if (pick < 85)
            req = adt_pkg::REQ_RUN;
        else
            req = adt_pkg::REQ_QUERY;
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 85)
            delay = adt_pkg::DELAY_W'($urandom_range(0, 2000));
        else if (pick < 95)
            delay = wide[adt_pkg::DELAY_W-1:0];
        else
            delay = '1;
        // mostly a steadily advancing clock, now and then a wild time stamp
        pick = $urandom_range(0, 99);
        if (pick < 94)
        begin
            clock_us = clock_us + adt_pkg::NOW_W'($urandom_range(0, 300));
            now = clock_us;
        end
        else if (pick < 97)
            now = wide[adt_pkg::NOW_W-1:0];
        else
            now = '1;
        offer_request(req, adt_pkg::ID_W'($urandom_range(0, adt_pkg::NUM_ALARMS - 1)),
                      delay, now);
    endtask

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        offer_request(adt_pkg::REQ_QUERY, 5'd0, '0, '0);
        offer_request(adt_pkg::REQ_RUN, 5'd0, '0, '0);
        offer_request(adt_pkg::REQ_DELETE, 5'd7, '0, 48'd1000);
        offer_request(adt_pkg::REQ_ADD, 5'd0, '0, 48'd1000);
        offer_request(adt_pkg::REQ_QUERY, 5'd0, '0, 48'd1000);
        offer_request(adt_pkg::REQ_ADD, 5'd31, '1, '1);
        offer_request(adt_pkg::REQ_ADD, 5'd5, '1, 48'hFFFF_FFFF_F000);
        offer_request(adt_pkg::REQ_QUERY, 5'd31, '0, 48'd1000);
        offer_request(adt_pkg::REQ_ADD, 5'd31, 40'd500, 48'd1000);
        offer_request(adt_pkg::REQ_ADD, 5'd1, 40'd10, 48'd1000);
        offer_request(adt_pkg::REQ_ADD, 5'd2, 40'd20, 48'd1000);
        offer_request(adt_pkg::REQ_ADD, 5'd3, 40'd30, 48'd1000);
        offer_request(adt_pkg::REQ_DELETE, 5'd2, '0, 48'd1005);
        offer_request(adt_pkg::REQ_DELETE, 5'd2, '0, 48'd1005);
        offer_request(adt_pkg::REQ_RUN, 5'd0, '0, 48'd1025);
        offer_request(adt_pkg::REQ_QUERY, 5'd0, '0, 48'd1025);
        offer_request(adt_pkg::REQ_ADD, 5'd10, 40'h55_5555_5555, 48'h5555_5555_5555);
        offer_request(adt_pkg::REQ_ADD, 5'd21, 40'hAA_AAAA_AAAA, 48'h2AAA_AAAA_AAAA);
        offer_request(adt_pkg::REQ_RUN, 5'd0, '0, '1);
        offer_request(adt_pkg::REQ_QUERY, 5'd0, '0, '0);

        // random part in four phases of input idling and result stalls
        clock_us = 48'd5000;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int n = 0; n < 83; n++)
            begin
                // long receiver hold-off while the sender keeps offering
                if (ph == 0 && n == 40)
                    hold_req = 1'b1;
                random_request();
            end
        end
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d requests driven, %0d result beats checked, %0d of them expiries",
                 sb.requests_seen, sb.results_seen, sb.expiries_seen);
        $display("covered saturation, re-arm, stale delete, due query and stall phases");
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/adt_pkg.sv
rtl/adt_deadline_ram.sv
rtl/alarm_deadline_table.sv
sim/testbench.sv
